// ===== sv/flvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flvd_pkg: shared types and constants of the container deframer
// Parser phases, result kinds, error codes and the result word layout.
// ----------------------------------------------------------------------------
package flvd_pkg;

   // Signature bytes "FLV" and the only legal header length
   localparam logic [23:0] SIG_WORD = 24'h464C56;
   localparam logic [31:0] HDR_LEN  = 32'd9;

   // Byte counts of the multi-byte fields
   localparam logic [2:0] SIG_BYTES  = 3'd3;
   localparam logic [2:0] WORD_BYTES = 3'd4;
   localparam logic [2:0] U24_BYTES  = 3'd3;

   typedef enum logic [3:0] {
      PH_SIG,
      PH_VER,
      PH_FLAGS,
      PH_HLEN,
      PH_PREV0,
      PH_TYPE,
      PH_SIZE,
      PH_TS,
      PH_TSX,
      PH_SID,
      PH_SKIP,
      PH_PREV,
      PH_ERR
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_TAG,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_SIGNATURE,
      ERR_HEADER_LEN,
      ERR_TRUNCATED
   } err_type;

   // One result word
   typedef struct packed {
      logic [31:0] previous_tag_size;
      logic [23:0] stream_id;
      logic [31:0] timestamp;
      logic [23:0] data_size;
      logic        encrypted;
      logic [4:0]  tag_type;
      logic        has_video;
      logic        has_audio;
      logic [7:0]  version;
      err_type     error_code;
      kind_type    kind;
   } rsp_item_type;

endpackage : flvd_pkg
`default_nettype wire

// ===== sv/flv_stream_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flv_stream_deframer: container header and tag parser
// Byte-wide stream in, one header, tag or error word out per parsed unit.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle (req_tlast marks the last byte of a
// stream) and never stalls the input for its own work: each byte updates the
// parser registers in the cycle it is accepted. A header word is returned
// once the size word after the file header is complete, a tag word once the
// size word after the tag is complete; payload bytes are counted and dropped.
// Results go into a two-word output queue, so input is only held back when
// two results are waiting. An error word (bad signature, bad header length,
// truncated stream) sticks: later bytes are taken and dropped until reset.
// A last byte that completes a header or tag returns the parser to its
// start, ready for a new stream.
module flv_stream_deframer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tlast,   // final_byte
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // [1:0] error_code, [9:2] version, [10] has_audio, [11] has_video,
   // [16:12] tag_type, [17] encrypted, [41:18] data_size,
   // [73:42] timestamp, [97:74] stream_id, [129:98] previous_tag_size
   output      logic [135:0] rsp_tdata,
   output      logic [1:0]   rsp_tuser    // [1:0] kind
);
   import flvd_pkg::*;

   // Parser registers
   phase_type    phase_ff,   phase_in;
   logic [2:0]   idx_ff,     idx_in;
   logic [31:0]  acc_ff,     acc_in;
   logic [23:0]  left_ff,    left_in;
   logic [9:0]   verfl_ff,   verfl_in;
   logic [5:0]   tbits_ff,   tbits_in;
   logic [23:0]  size_ff,    size_in;
   logic [31:0]  time_ff,    time_in;
   logic [23:0]  stream_ff,  stream_in;

   // Output queue: head word and one waiting word behind it
   rsp_item_type head_ff,    head_in;
   rsp_item_type tail_ff,    tail_in;
   logic         head_v_ff,  head_v_in;
   logic         tail_v_ff,  tail_v_in;

   logic         accept;
   logic         pop;
   logic         res_valid;
   rsp_item_type res;
   logic         clean;
   logic         err_hit;
   logic [31:0]  acc_shift;
   logic [2:0]   idx_inc;
   logic [23:0]  left_dec;
   logic         head_v_mid;
   rsp_item_type head_mid;

   assign req_tready = ~tail_v_ff;
   assign accept     = req_tvalid & req_tready;
   assign pop        = head_v_ff & rsp_tready;

   assign acc_shift = {acc_ff[23:0], req_tdata};
   assign idx_inc   = idx_ff + 3'd1;
   assign left_dec  = left_ff - 24'd1;

   // Parser next state and result
   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      left_in   = left_ff;
      verfl_in  = verfl_ff;
      tbits_in  = tbits_ff;
      size_in   = size_ff;
      time_in   = time_ff;
      stream_in = stream_ff;
      res       = '0;
      res_valid = 1'b0;
      clean     = 1'b0;
      err_hit   = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_SIG: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == SIG_BYTES) begin
                  idx_in = '0;
                  if (acc_shift[23:0] != SIG_WORD) begin
                     err_hit        = 1'b1;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_SIGNATURE;
                     phase_in       = PH_ERR;
                  end else begin
                     acc_in   = '0;
                     phase_in = PH_VER;
                  end
               end
            end
            PH_VER: begin
               verfl_in = {req_tdata, 2'b00};
               phase_in = PH_FLAGS;
            end
            PH_FLAGS: begin
               verfl_in = {verfl_ff[9:2], req_tdata[2], req_tdata[0]};
               phase_in = PH_HLEN;
            end
            PH_HLEN: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == WORD_BYTES) begin
                  idx_in = '0;
                  if (acc_shift != HDR_LEN) begin
                     err_hit        = 1'b1;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERROR;
                     res.error_code = ERR_HEADER_LEN;
                     phase_in       = PH_ERR;
                  end else begin
                     acc_in   = '0;
                     phase_in = PH_PREV0;
                  end
               end
            end
            PH_PREV0: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == WORD_BYTES) begin
                  res_valid             = 1'b1;
                  res.kind              = KIND_HEADER;
                  res.version           = verfl_ff[9:2];
                  res.has_audio         = verfl_ff[1];
                  res.has_video         = verfl_ff[0];
                  res.previous_tag_size = acc_shift;
                  idx_in                = '0;
                  acc_in                = '0;
                  phase_in              = PH_TYPE;
                  clean                 = 1'b1;
               end
            end
            PH_TYPE: begin
               tbits_in = req_tdata[5:0];
               phase_in = PH_SIZE;
            end
            PH_SIZE: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == U24_BYTES) begin
                  size_in  = acc_shift[23:0];
                  left_in  = acc_shift[23:0];
                  idx_in   = '0;
                  acc_in   = '0;
                  phase_in = PH_TS;
               end
            end
            PH_TS: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == U24_BYTES) begin
                  time_in  = {8'd0, acc_shift[23:0]};
                  idx_in   = '0;
                  acc_in   = '0;
                  phase_in = PH_TSX;
               end
            end
            PH_TSX: begin
               time_in  = {req_tdata, time_ff[23:0]};
               phase_in = PH_SID;
            end
            PH_SID: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == U24_BYTES) begin
                  stream_in = acc_shift[23:0];
                  idx_in    = '0;
                  acc_in    = '0;
                  phase_in  = (left_ff != '0) ? PH_SKIP : PH_PREV;
               end
            end
            PH_SKIP: begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_PREV;
               end
            end
            PH_PREV: begin
               acc_in = acc_shift;
               idx_in = idx_inc;
               if (idx_inc == WORD_BYTES) begin
                  res_valid             = 1'b1;
                  res.kind              = KIND_TAG;
                  res.tag_type          = tbits_ff[4:0];
                  res.encrypted         = tbits_ff[5];
                  res.data_size         = size_ff;
                  res.timestamp         = time_ff;
                  res.stream_id         = stream_ff;
                  res.previous_tag_size = acc_shift;
                  idx_in                = '0;
                  acc_in                = '0;
                  phase_in              = PH_TYPE;
                  clean                 = 1'b1;
               end
            end
            PH_ERR: begin
               // sticky: drop the word
            end
            default: begin
               err_hit        = 1'b1;
               res_valid      = 1'b1;
               res            = '0;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TRUNCATED;
               phase_in       = PH_ERR;
            end
         endcase

         // Last byte of a stream: restart after a clean unit, else truncated
         if (req_tlast && !err_hit && phase_ff != PH_ERR) begin
            if (clean) begin
               phase_in  = PH_SIG;
               idx_in    = '0;
               acc_in    = '0;
               left_in   = '0;
               verfl_in  = '0;
               tbits_in  = '0;
               size_in   = '0;
               time_in   = '0;
               stream_in = '0;
            end else begin
               res_valid      = 1'b1;
               res            = '0;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TRUNCATED;
               phase_in       = PH_ERR;
            end
         end
      end
   end

   // Output queue: pop shifts the waiting word forward, push fills first free
   always_comb begin
      head_mid   = head_ff;
      head_v_mid = head_v_ff;
      tail_in    = tail_ff;
      tail_v_in  = tail_v_ff;
      if (pop) begin
         head_mid   = tail_ff;
         head_v_mid = tail_v_ff;
         tail_v_in  = 1'b0;
      end
      head_in   = head_mid;
      head_v_in = head_v_mid;
      if (res_valid) begin
         if (!head_v_mid) begin
            head_in   = res;
            head_v_in = 1'b1;
         end else begin
            tail_in   = res;
            tail_v_in = 1'b1;
         end
      end
   end

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIG;
         idx_ff    <= '0;
         acc_ff    <= '0;
         left_ff   <= '0;
         verfl_ff  <= '0;
         tbits_ff  <= '0;
         size_ff   <= '0;
         time_ff   <= '0;
         stream_ff <= '0;
         head_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
         verfl_ff  <= verfl_in;
         tbits_ff  <= tbits_in;
         size_ff   <= size_in;
         time_ff   <= time_in;
         stream_ff <= stream_in;
         head_v_ff <= head_v_in;
         tail_v_ff <= tail_v_in;
      end
   end

   // Result words
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = head_v_ff;
   assign rsp_tuser  = head_ff.kind;
   assign rsp_tdata  = {6'd0,
                        head_ff.previous_tag_size,
                        head_ff.stream_id,
                        head_ff.timestamp,
                        head_ff.data_size,
                        head_ff.encrypted,
                        head_ff.tag_type,
                        head_ff.has_video,
                        head_ff.has_audio,
                        head_ff.version,
                        head_ff.error_code};

endmodule : flv_stream_deframer
`default_nettype wire

// ===== verif/flv_stream_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_stream_deframer_tb: self-checking bench for the container deframer
// Feeds whole container streams (header, tags, payload, size words) one byte
// per word and checks every header, tag and error word against a local
// parser model. Idle and stall rates change from stream to stream. Errors
// stick until reset, so each run ends with one broken stream.
// ----------------------------------------------------------------------------
module flv_stream_deframer_tb;
   import flvd_pkg::*;

   localparam int ITEM_TARGET = 700;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_REPORTS = 10;

   // One expected result word, field by field
   typedef struct packed {
      kind_type    kind;
      err_type     error_code;
      logic [7:0]  version;
      logic        has_audio;
      logic        has_video;
      logic [4:0]  tag_type;
      logic        encrypted;
      logic [23:0] data_size;
      logic [31:0] timestamp;
      logic [23:0] stream_id;
      logic [31:0] prev_size;
   } deframe_word_type;

   // Parser model plus the queue of words still owed by the block
   class deframe_scoreboard;
      phase_type        phase;
      logic [2:0]       byte_index;
      logic [31:0]      shift_reg;
      logic [23:0]      payload_left;
      logic [9:0]       ver_flags;      // version, audio, video
      logic [5:0]       type_bits;      // encrypted, type
      logic [23:0]      tag_size;
      logic [31:0]      tag_time;
      logic [23:0]      tag_stream;
      deframe_word_type pending[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase        = PH_SIG;
         byte_index   = '0;
         shift_reg    = '0;
         payload_left = '0;
         ver_flags    = '0;
         type_bits    = '0;
         tag_size     = '0;
         tag_time     = '0;
         tag_stream   = '0;
      endfunction

      function void shift_byte(logic [7:0] b);
         shift_reg  = {shift_reg[23:0], b};
         byte_index = byte_index + 3'd1;
      endfunction

      function void push_error(err_type code);
         deframe_word_type w;
         w            = '0;
         w.kind       = KIND_ERROR;
         w.error_code = code;
         pending.push_back(w);
         phase = PH_ERR;
      endfunction

      // Advance the model by one accepted byte
      function void note_byte(logic [7:0] b, logic last);
         deframe_word_type w;
         bit               done;
         w    = '0;
         done = 1'b0;
         if (phase == PH_ERR) return;
         case (phase)
            PH_SIG: begin
               shift_byte(b);
               if (byte_index >= SIG_BYTES) begin
                  byte_index = '0;
                  if (shift_reg[23:0] != SIG_WORD) begin
                     push_error(ERR_SIGNATURE);
                     return;
                  end
                  shift_reg = '0;
                  phase     = PH_VER;
               end
            end
            PH_VER: begin
               ver_flags = {b, 2'b00};
               phase     = PH_FLAGS;
            end
            PH_FLAGS: begin
               ver_flags = {ver_flags[9:2], b[2], b[0]};
               phase     = PH_HLEN;
            end
            PH_HLEN: begin
               shift_byte(b);
               if (byte_index >= WORD_BYTES) begin
                  byte_index = '0;
                  if (shift_reg != HDR_LEN) begin
                     push_error(ERR_HEADER_LEN);
                     return;
                  end
                  shift_reg = '0;
                  phase     = PH_PREV0;
               end
            end
            PH_PREV0: begin
               shift_byte(b);
               if (byte_index >= WORD_BYTES) begin
                  w.kind      = KIND_HEADER;
                  w.version   = ver_flags[9:2];
                  w.has_audio = ver_flags[1];
                  w.has_video = ver_flags[0];
                  w.prev_size = shift_reg;
                  done        = 1'b1;
                  byte_index  = '0;
                  shift_reg   = '0;
                  phase       = PH_TYPE;
               end
            end
            PH_TYPE: begin
               type_bits = b[5:0];
               phase     = PH_SIZE;
            end
            PH_SIZE: begin
               shift_byte(b);
               if (byte_index >= U24_BYTES) begin
                  tag_size     = shift_reg[23:0];
                  payload_left = shift_reg[23:0];
                  byte_index   = '0;
                  shift_reg    = '0;
                  phase        = PH_TS;
               end
            end
            PH_TS: begin
               shift_byte(b);
               if (byte_index >= U24_BYTES) begin
                  tag_time   = {8'h00, shift_reg[23:0]};
                  byte_index = '0;
                  shift_reg  = '0;
                  phase      = PH_TSX;
               end
            end
            PH_TSX: begin
               tag_time[31:24] = b;
               phase           = PH_SID;
            end
            PH_SID: begin
               shift_byte(b);
               if (byte_index >= U24_BYTES) begin
                  tag_stream = shift_reg[23:0];
                  byte_index = '0;
                  shift_reg  = '0;
                  // empty payload goes straight to the size word
                  phase = (payload_left != 24'd0) ? PH_SKIP : PH_PREV;
               end
            end
            PH_SKIP: begin
               payload_left = payload_left - 24'd1;
               if (payload_left == 24'd0) phase = PH_PREV;
            end
            PH_PREV: begin
               shift_byte(b);
               if (byte_index >= WORD_BYTES) begin
                  w.kind      = KIND_TAG;
                  w.tag_type  = type_bits[4:0];
                  w.encrypted = type_bits[5];
                  w.data_size = tag_size;
                  w.timestamp = tag_time;
                  w.stream_id = tag_stream;
                  w.prev_size = shift_reg;
                  done        = 1'b1;
                  byte_index  = '0;
                  shift_reg   = '0;
                  phase       = PH_TYPE;
               end
            end
            default: begin
               push_error(ERR_TRUNCATED);
               return;
            end
         endcase

         // last byte: clean end restarts the parser, anything else truncates
         if (last) begin
            if (done) begin
               pending.push_back(w);
               restart();
            end else begin
               push_error(ERR_TRUNCATED);
            end
            return;
         end
         if (done) pending.push_back(w);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("error: %s expected %h, got %h", name, want, got);
         end
      endfunction

      // Check one accepted result word against the oldest expectation
      function void check_result(logic [135:0] d, logic [1:0] u);
         deframe_word_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("error: unexpected word, kind %0d data %h", u, d);
            return;
         end
         want = pending.pop_front();
         compare_field("kind",              want.kind,       u);
         compare_field("error_code",        want.error_code, d[1:0]);
         compare_field("version",           want.version,    d[9:2]);
         compare_field("has_audio",         want.has_audio,  d[10]);
         compare_field("has_video",         want.has_video,  d[11]);
         compare_field("tag_type",          want.tag_type,   d[16:12]);
         compare_field("encrypted",         want.encrypted,  d[17]);
         compare_field("data_size",         want.data_size,  d[41:18]);
         compare_field("timestamp",         want.timestamp,  d[73:42]);
         compare_field("stream_id",         want.stream_id,  d[97:74]);
         compare_field("previous_tag_size", want.prev_size,  d[129:98]);
         compare_field("padding",           32'd0,           d[135:130]);
      endfunction
   endclass

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;   // [7:0] data_byte
   logic         req_tlast  = 1'b0; // final_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [1:0] error_code, [9:2] version, [10] has_audio, [11] has_video,
   // [16:12] tag_type, [17] encrypted, [41:18] data_size,
   // [73:42] timestamp, [97:74] stream_id, [129:98] previous_tag_size
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;         // [1:0] kind

   deframe_scoreboard sb = new();
   logic [7:0]        frame_q[$];
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                bytes_sent     = 0;
   int                quiet_cycles   = 0;

   flv_stream_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Random receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Both handshakes seen at the same edge; inputs are noted first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog on cycles with no word moving on either side
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("error: no progress for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Big-endian multi-byte field into the frame buffer
   function automatic void push_be(logic [31:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
   endfunction

   function automatic void push_header(logic [23:0] sig, logic [7:0] ver, logic [7:0] flags,
                                       logic [31:0] hlen, logic [31:0] prev);
      push_be(sig, 3);
      frame_q.push_back(ver);
      frame_q.push_back(flags);
      push_be(hlen, 4);
      push_be(prev, 4);
   endfunction

   function automatic void push_tag(logic [7:0] type_byte, logic [23:0] size, logic [23:0] ts,
                                    logic [7:0] tsx, logic [23:0] sid, logic [31:0] prev);
      frame_q.push_back(type_byte);
      push_be(size, 3);
      push_be(ts, 3);
      frame_q.push_back(tsx);
      push_be(sid, 3);
      for (int i = 0; i < size; i++) frame_q.push_back(8'($urandom));
      push_be(prev, 4);
   endfunction

   // Mostly short payloads, a few over 255 bytes so the middle size byte is set
   function automatic void push_random_tag();
      int          roll;
      logic [23:0] size;
      roll = $urandom_range(99);
      if (roll < 80)      size = 24'($urandom_range(0, 8));
      else if (roll < 96) size = 24'($urandom_range(9, 40));
      else                size = 24'($urandom_range(256, 300));
      push_tag(8'($urandom), size, 24'($urandom), 8'($urandom), 24'($urandom), $urandom);
   endfunction

   // One byte word; valid stays high into the next call when no idle is drawn
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the buffer up to fin_at, marking that byte as the last one
   task automatic send_frame(input int fin_at);
      for (int i = 0; i <= fin_at; i++) send_byte(frame_q[i], i == fin_at);
      frame_q.delete();
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int          stream_no;
      int          end_case;
      int          fin_at;
      logic [23:0] bad_sig;
      logic [31:0] bad_len;

      stream_no = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: header-only stream with all-ones fields, then a stream
      // with one zero-payload tag whose fields are at their extremes
      push_header(SIG_WORD, 8'hFF, 8'h05, HDR_LEN, 32'hFFFF_FFFF);
      send_frame(frame_q.size() - 1);
      push_header(SIG_WORD, 8'h00, 8'hFA, HDR_LEN, 32'h0000_0000);
      push_tag(8'hFF, 24'd0, 24'hFF_FFFF, 8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
      send_frame(frame_q.size() - 1);

      // Random well-formed streams; idle profile rotates per stream
      while (bytes_sent < ITEM_TARGET) begin
         case (stream_no % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            default: begin
               send_idle_pct  = 21;
               recv_stall_pct = 21;
            end
         endcase
         if (stream_no % 5 == 3) drain_results();
         push_header(SIG_WORD, 8'($urandom), 8'($urandom), HDR_LEN, $urandom);
         repeat ($urandom_range(0, 4)) push_random_tag();
         send_frame(frame_q.size() - 1);
         stream_no++;
      end

      // One broken stream at the end, since any error sticks until reset
      send_idle_pct  = 21;
      recv_stall_pct = 21;
      end_case = $urandom_range(0, 4);
      bad_sig  = SIG_WORD ^ (24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2)));
      bad_len  = ($urandom_range(1) != 0) ? $urandom : (HDR_LEN ^ (32'd1 << $urandom_range(31)));
      if (bad_len == HDR_LEN) bad_len = 32'd0;
      case (end_case)
         0: begin
            push_header(bad_sig, 8'($urandom), 8'($urandom), HDR_LEN, $urandom);
            send_frame(frame_q.size() - 1);
         end
         1: begin
            push_header(SIG_WORD, 8'($urandom), 8'($urandom), bad_len, $urandom);
            send_frame(frame_q.size() - 1);
         end
         2: begin
            // last flag anywhere but a clean end point
            push_header(SIG_WORD, 8'($urandom), 8'($urandom), HDR_LEN, $urandom);
            push_random_tag();
            fin_at = $urandom_range(0, frame_q.size() - 2);
            if (fin_at == 12) fin_at = 11;
            send_frame(fin_at);
         end
         3: begin
            // last flag on the final signature byte, where the mismatch is found
            push_header(bad_sig, 8'($urandom), 8'($urandom), HDR_LEN, $urandom);
            send_frame(2);
         end
         default: begin
            // last flag on the final byte of a bad header length
            push_header(SIG_WORD, 8'($urandom), 8'($urandom), bad_len, $urandom);
            send_frame(8);
         end
      endcase

      // Trailing noise must be dropped
      repeat ($urandom_range(4, 16)) frame_q.push_back(8'($urandom));
      send_frame(frame_q.size() - 1);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         if (sb.pending.size() != 0)
            $display("error: %0d expected words never arrived", sb.pending.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
